FILE: design/gde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gde_pkg: shared definitions for the 3D Gaussian density evaluator
// Fixed-point formats, register indexes, pipeline depth and the constant
// table of 2^(-j/N) values used by the exponential stage.
// ----------------------------------------------------------------------------
package gde_pkg;

  // Fraction bits of coordinates and of the exponent table size.
  localparam int COORD_FRAC_BITS   = 16;
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int IV_FRAC           = 16;

  // Pipeline depth of each part and of the whole block.
  localparam int AXIS_STAGES = 3;
  localparam int EXP_STAGES  = 5;
  localparam int LATENCY     = AXIS_STAGES + EXP_STAGES + 1;

  // Widths inside the exponential stage.
  localparam int ARG_W  = COORD_FRAC_BITS + 6;             // holds up to 32.0
  localparam int PY_W   = ARG_W + 31;                       // arg * log2(e)
  localparam int K_W    = 6;                                // integer exponent
  localparam int TAB_AW = $clog2(EXP_TABLE_ENTRIES + 1);    // table address
  localparam int S_W    = 30 + TAB_AW;                      // frac * entries

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] Q30_ONE   = 64'd1073741824;
  localparam int          TAYLOR_TERMS = 24;

  // Largest argument that is not forced to a zero result: 32.0.
  localparam logic [30:0] ARG_LIMIT = 31'(32) << COORD_FRAC_BITS;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_CENTER_Z  = 3'd2,
    CFG_INV_VAR_X = 3'd3,
    CFG_INV_VAR_Y = 3'd4,
    CFG_INV_VAR_Z = 3'd5,
    CFG_PEAK      = 3'd6
  } cfg_reg_t;

  // Table of 2^(-j/N) in Q1.30, j = 0 .. N.
  typedef logic [EXP_TABLE_ENTRIES:0][30:0] exp_tab_t;

  // Unsigned quotient by shift and subtract, used only while the table is built.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Each entry is 1 / e^(j*ln2/N), with e^u summed as a Taylor series.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] u;
    logic [63:0] acc;
    logic [63:0] term;
    for (int j = 0; j <= EXP_TABLE_ENTRIES; j++) begin
      u    = udiv64(LN2_Q30 * 64'(j), 64'(EXP_TABLE_ENTRIES));
      acc  = Q30_ONE;
      term = Q30_ONE;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = udiv64((term * u) >> 30, 64'(n));
        acc  = acc + term;
      end
      tab[j] = 31'(udiv64(64'd1 << 60, acc));
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: design/gde_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gde_axis: weighted squared distance along one axis
// Three stages: offset magnitude, square, saturate and scale by the
// inverse variance. The output is the raw 64-bit product.
// ----------------------------------------------------------------------------
module gde_axis import gde_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] point,
  input  logic signed [31:0] center,
  input  logic        [31:0] inv_var,
  output logic        [63:0] prod_r
);

  logic signed [32:0] diff;
  logic        [32:0] neg;
  logic        [31:0] mag_nxt;
  logic        [31:0] mag_r;
  logic        [63:0] sqp_nxt;
  logic        [63:0] sqp_r;
  logic        [63:0] sq_shift;
  logic        [31:0] sq_sat;
  logic        [63:0] prod_nxt;

  // Offset from the center is exact in 33 bits; its magnitude fits in 32.
  always_comb begin
    diff    = 33'(point) - 33'(center);
    neg     = 33'(-diff);
    mag_nxt = diff[32] ? neg[31:0] : diff[31:0];
  end

  // Square of the magnitude.
  assign sqp_nxt = 64'(mag_r) * 64'(mag_r);

  // Drop the extra fraction bits, clamp to 32 bits, then weight.
  always_comb begin
    sq_shift = sqp_r >> COORD_FRAC_BITS;
    sq_sat   = (|sq_shift[63:32]) ? 32'hFFFF_FFFF : sq_shift[31:0];
    prod_nxt = 64'(sq_sat) * 64'(inv_var);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_nxt;
      sqp_r  <= sqp_nxt;
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: design/gde_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gde_exp: exponential of the summed distance
// Five stages: sum and clamp, scale by log2(e), table lookup, interpolation
// product, and the final interpolate and shift. Output is exp(-arg) in Q1.30.
// ----------------------------------------------------------------------------
module gde_exp import gde_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] prod_x,
  input  logic [63:0] prod_y,
  input  logic [63:0] prod_z,
  output logic [30:0] e_r
);

  // Stage 1: sum, saturate, halve and range check.
  logic [49:0]       sum;
  logic [30:0]       arg_full;
  logic [ARG_W-1:0]  arg_nxt;
  logic [ARG_W-1:0]  arg_r;
  logic              zero_nxt;
  logic              zero1_r;

  always_comb begin
    sum      = 50'(prod_x[63:IV_FRAC]) + 50'(prod_y[63:IV_FRAC])
             + 50'(prod_z[63:IV_FRAC]);
    arg_full = (|sum[49:32]) ? 31'h7FFF_FFFF : sum[31:1];
    zero_nxt = arg_full > ARG_LIMIT;
    arg_nxt  = arg_full[ARG_W-1:0];
  end

  // Stage 2: convert to a power of two.
  logic [PY_W-1:0] py;
  logic [K_W-1:0]  k_nxt;
  logic [29:0]     frac_nxt;
  logic [K_W-1:0]  k2_r;
  logic [29:0]     frac_r;
  logic            zero2_r;

  always_comb begin
    py       = PY_W'(arg_r) * PY_W'(LOG2E_Q30);
    frac_nxt = py[COORD_FRAC_BITS +: 30];
    k_nxt    = py[COORD_FRAC_BITS + 30 +: K_W];
  end

  // Stage 3: table address, weight and the two neighboring entries.
  logic [S_W-1:0]    s;
  logic [TAB_AW-1:0] idx;
  logic [TAB_AW-1:0] idx_hi;
  logic [30:0]       a_nxt;
  logic [30:0]       diff_nxt;
  logic [30:0]       a3_r;
  logic [30:0]       diff_r;
  logic [29:0]       w_r;
  logic [K_W-1:0]    k3_r;
  logic              zero3_r;

  always_comb begin
    s   = S_W'(frac_r) * S_W'(EXP_TABLE_ENTRIES);
    idx = s[S_W-1:30];
    if (idx > TAB_AW'(EXP_TABLE_ENTRIES - 1)) begin
      idx = TAB_AW'(EXP_TABLE_ENTRIES - 1);
    end
    idx_hi   = idx + TAB_AW'(1);
    a_nxt    = EXP_TAB[idx];
    diff_nxt = EXP_TAB[idx] - EXP_TAB[idx_hi];
  end

  // Stage 4: interpolation product.
  logic [60:0]    ip;
  logic [30:0]    ip_nxt;
  logic [30:0]    ip_r;
  logic [30:0]    a4_r;
  logic [K_W-1:0] k4_r;
  logic           zero4_r;

  always_comb begin
    ip     = 61'(diff_r) * 61'(w_r);
    ip_nxt = ip[60:30];
  end

  // Stage 5: interpolated value shifted down by the integer exponent.
  logic [30:0] e_nxt;

  always_comb begin
    e_nxt = zero4_r ? 31'd0 : ((a4_r - ip_r) >> k4_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arg_r   <= arg_nxt;
      zero1_r <= zero_nxt;

      k2_r    <= k_nxt;
      frac_r  <= frac_nxt;
      zero2_r <= zero1_r;

      a3_r    <= a_nxt;
      diff_r  <= diff_nxt;
      w_r     <= s[29:0];
      k3_r    <= k2_r;
      zero3_r <= zero2_r;

      ip_r    <= ip_nxt;
      a4_r    <= a3_r;
      k4_r    <= k3_r;
      zero4_r <= zero3_r;

      e_r     <= e_nxt;
    end
  end

endmodule

FILE: design/gaussian_density_eval_3d.sv
`timescale 1ns / 1ps
// An accepted item passes the axis, exponential and output registers before its result is on the output.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits on out_ready, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and returns the
// registers to center 0, inverse variance 1.0 and peak 0.
// ----------------------------------------------------------------------------
// gaussian_density_eval_3d: axis-aligned 3D Gaussian density
// Evaluates peak * exp(-0.5 * sum(d^2 * inv_var)) for one query point per
// item, with a configuration write channel for center, variances and peak.
// ----------------------------------------------------------------------------
module gaussian_density_eval_3d import gde_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_density
);

  // Configuration registers.
  logic signed [31:0] center_r [3];
  logic        [31:0] inv_var_r [3];
  logic        [31:0] peak_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        center_r[i]  <= '0;
        inv_var_r[i] <= 32'd65536;
      end
      peak_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CENTER_X:  center_r[0]  <= cfg_data;
        CFG_CENTER_Y:  center_r[1]  <= cfg_data;
        CFG_CENTER_Z:  center_r[2]  <= cfg_data;
        CFG_INV_VAR_X: inv_var_r[0] <= cfg_data;
        CFG_INV_VAR_Y: inv_var_r[1] <= cfg_data;
        CFG_INV_VAR_Z: inv_var_r[2] <= cfg_data;
        CFG_PEAK:      peak_r       <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Pipeline advance: move whenever the output register is free or taken.
  logic               adv;
  logic [LATENCY-1:0] valid_r;
  logic [LATENCY-1:0] valid_nxt;

  assign adv       = ~valid_r[LATENCY-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = valid_r[LATENCY-1];
  assign valid_nxt = {valid_r[LATENCY-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  // Per-axis weighted squared distance.
  logic signed [31:0] point [3];
  logic        [63:0] prod [3];

  assign point[0] = in_point_x;
  assign point[1] = in_point_y;
  assign point[2] = in_point_z;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    gde_axis u_axis (
      .clk     (clk),
      .en      (adv),
      .point   (point[g]),
      .center  (center_r[g]),
      .inv_var (inv_var_r[g]),
      .prod_r  (prod[g])
    );
  end

  // Exponential of the summed distance.
  logic [30:0] e;

  gde_exp u_exp (
    .clk    (clk),
    .en     (adv),
    .prod_x (prod[0]),
    .prod_y (prod[1]),
    .prod_z (prod[2]),
    .e_r    (e)
  );

  // Output register: scale by the peak value.
  logic [62:0] dens_prod;
  logic [31:0] density_nxt;
  logic [31:0] density_r;

  always_comb begin
    dens_prod   = 63'(peak_r) * 63'(e);
    density_nxt = dens_prod[61:30];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      density_r <= density_nxt;
    end
  end

  assign out_density = density_r;

endmodule
